// File: hdl/word_clock_matrix_driver_macros.svh
// assertion macros for the word clock matrix driver
`ifndef WORD_CLOCK_MATRIX_DRIVER_MACROS_SVH
`define WORD_CLOCK_MATRIX_DRIVER_MACROS_SVH

// same-cycle implication, checked out of reset
`define WCM_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, checked out of reset
`define WCM_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: hdl/wcm_pkg.sv
// shared types, layout tables and helpers for the word clock matrix driver
package wcm_pkg;

    localparam int ROWS  = 10;
    localparam int COLS  = 12;
    localparam int ROW_W = 4;

    typedef logic [COLS-1:0]  t_row;
    typedef t_row [ROWS-1:0]  t_frame;
    typedef logic [ROW_W-1:0] t_row_idx;

    // control from the pipeline to the frame store
    typedef struct packed {
        logic load;
        logic step;
    } t_scan_ctrl;

    localparam t_row_idx LAST_ROW = t_row_idx'(ROWS - 1);

    localparam logic [5:0] FIVE_MINUTE    = 6'd5;
    localparam logic [5:0] ADVANCE_MINUTE = 6'd35;

    // fixed words outside the tables
    localparam t_row_idx E_ROW      = 4'd7;
    localparam t_row     E_BITS     = 12'h800;
    localparam t_row_idx MENO_ROW   = 4'd6;
    localparam t_row     MENO_BITS  = 12'h01E;
    localparam t_row     DOT_BITS   = 12'h001;
    localparam t_row_idx ONE_ROW    = 4'd1;
    localparam t_row     ONE_BITS   = 12'hA00;
    localparam t_row_idx PLURAL_ROW = 4'd0;
    localparam t_row     PLURAL_BITS = 12'hF6E;
    localparam logic [3:0] HOUR_ONE = 4'd1;

    // minute words by five-minute step
    localparam t_row_idx MINUTE_ROW [13] = '{
        4'd0, 4'd8, 4'd9, 4'd7, 4'd8, 4'd8, 4'd9,
        4'd8, 4'd8, 4'd7, 4'd9, 4'd8, 4'd0
    };
    localparam t_row MINUTE_BITS [13] = '{
        12'h000, 12'h07E, 12'hF80, 12'h37E, 12'hF80, 12'hFFE, 12'h03E,
        12'hFFE, 12'hF80, 12'h37E, 12'hF80, 12'h07E, 12'h000
    };

    // hour words by displayed hour
    localparam t_row_idx HOUR_ROW [12] = '{
        4'd4, 4'd1, 4'd1, 4'd2, 4'd5, 4'd6, 4'd5, 4'd4, 4'd2, 4'd2, 4'd3, 4'd3
    };
    localparam t_row HOUR_BITS [12] = '{
        12'hFC0, 12'h1C0, 12'h01C, 12'hE00, 12'hFE0, 12'hFC0,
        12'h00E, 12'h03E, 12'h1E0, 12'h01E, 12'hF80, 12'h07E
    };

    // minute / 5 for 0..63 as multiply by 13 and shift by 6
    function automatic logic [3:0] div5(input logic [5:0] m);
        logic [9:0] prod;
        prod = 10'(m) * 10'd13;
        return prod[9:6];
    endfunction

    // value mod 12 for 0..32
    function automatic logic [3:0] mod12(input logic [5:0] v);
        logic [5:0] r;
        r = v;
        if (r >= 6'd24) begin
            r = r - 6'd24;
        end else if (r >= 6'd12) begin
            r = r - 6'd12;
        end
        return r[3:0];
    endfunction

endpackage

// File: hdl/wcm_time_decode.sv
// decodes hour, minute and sync flag into a full LED frame
module wcm_time_decode (
    input  logic [4:0]      i_hour,
    input  logic [5:0]      i_minute,
    input  logic            i_sync_flag,
    output wcm_pkg::t_frame o_frame
);
    import wcm_pkg::*;

    logic       advance;
    logic [3:0] step;
    logic [5:0] step_base;
    logic [2:0] dots;
    logic [5:0] hour_adv;
    logic [3:0] shown;

    // arithmetic on the time fields
    always_comb begin
        advance   = (i_minute >= ADVANCE_MINUTE);
        step      = div5(i_minute);
        step_base = 6'({step, 2'b00}) + 6'(step);
        dots      = 3'(i_minute - step_base);
        hour_adv  = 6'(i_hour) + 6'(advance);
        shown     = mod12(hour_adv);
    end

    // word lighting
    always_comb begin
        o_frame = '0;
        if (i_minute >= FIVE_MINUTE) begin
            if (advance) begin
                o_frame[MENO_ROW] = MENO_BITS;
            end else begin
                o_frame[E_ROW] = E_BITS;
            end
        end
        o_frame[MINUTE_ROW[step]] = o_frame[MINUTE_ROW[step]] | MINUTE_BITS[step];
        // minute dots on the first four rows
        if (!i_sync_flag) begin
            for (int i = 0; i < 4; i++) begin
                if (3'(i) < dots) begin
                    o_frame[i] = o_frame[i] | DOT_BITS;
                end
            end
        end
        if (shown == HOUR_ONE) begin
            o_frame[ONE_ROW] = o_frame[ONE_ROW] | ONE_BITS;
        end else begin
            o_frame[PLURAL_ROW] = o_frame[PLURAL_ROW] | PLURAL_BITS;
        end
        o_frame[HOUR_ROW[shown]] = o_frame[HOUR_ROW[shown]] | HOUR_BITS[shown];
    end

endmodule

// File: hdl/wcm_frame_scan.sv
// frame store and row scan counter
module wcm_frame_scan (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  wcm_pkg::t_scan_ctrl i_ctrl,
    input  wcm_pkg::t_frame   i_frame,
    output wcm_pkg::t_row_idx o_row,
    output wcm_pkg::t_row     o_row_bits
);
    import wcm_pkg::*;

    t_frame   r_frame;
    t_row_idx r_scan_row;
    t_row_idx n_scan_row;

    // next row with wrap after the last one
    always_comb begin
        n_scan_row = (r_scan_row == LAST_ROW) ? '0 : r_scan_row + t_row_idx'(1);
    end

    // frame replace and row advance
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_frame    <= '0;
            r_scan_row <= '0;
        end else begin
            if (i_ctrl.load) begin
                r_frame <= i_frame;
            end
            if (i_ctrl.step) begin
                r_scan_row <= n_scan_row;
            end
        end
    end

    assign o_row      = r_scan_row;
    assign o_row_bits = r_frame[r_scan_row];

endmodule

// File: hdl/word_clock_matrix_driver.sv
// top level of the word clock matrix driver: input register, decode, result register
//
//  channel | valid   | stall   | payload
//  --------+---------+---------+-------------------------------------------
//  input   | i_valid | o_stall | i_kind, i_hour, i_minute, i_sync_flag
//  output  | o_valid | i_stall | o_row_enable, o_column_drive, o_row_number
//
// One transaction per cycle unless stalled; scan rows leave via the result register.
// A time-set transaction replaces the frame when it leaves the input register.
// Reset darkens the frame and restarts the scan at row 0.
// The input register holds while a scan tick waits behind a stalled result.
`include "word_clock_matrix_driver_macros.svh"

module word_clock_matrix_driver (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_stall,
    input  logic        i_kind,
    input  logic [4:0]  i_hour,
    input  logic [5:0]  i_minute,
    input  logic        i_sync_flag,
    output logic        o_valid,
    input  logic        i_stall,
    output logic [9:0]  o_row_enable,
    output logic [11:0] o_column_drive,
    output logic [3:0]  o_row_number
);
    import wcm_pkg::*;

    logic       r_in_valid;
    logic       r_kind;
    logic [4:0] r_hour;
    logic [5:0] r_minute;
    logic       r_sync_flag;

    logic        r_out_valid;
    logic [ROWS-1:0] r_row_enable;
    t_row        r_column_drive;
    t_row_idx    r_row_number;

    logic       out_free;
    logic       advance;
    logic       take_in;
    t_scan_ctrl scan_ctrl;
    t_frame     new_frame;
    t_row_idx   scan_row;
    t_row       scan_bits;

    // handshake
    assign out_free  = !r_out_valid || !i_stall;
    assign advance   = r_in_valid && (r_kind || out_free);
    assign o_stall   = r_in_valid && !advance;
    assign take_in   = i_valid && !o_stall;

    assign scan_ctrl.load = advance && r_kind;
    assign scan_ctrl.step = advance && !r_kind;

    // input register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (take_in || advance) begin
            r_in_valid <= take_in;
        end
    end

    always_ff @(posedge i_clk) begin
        if (take_in) begin
            r_kind      <= i_kind;
            r_hour      <= i_hour;
            r_minute    <= i_minute;
            r_sync_flag <= i_sync_flag;
        end
    end

    wcm_time_decode u_decode (
        .i_hour      (r_hour),
        .i_minute    (r_minute),
        .i_sync_flag (r_sync_flag),
        .o_frame     (new_frame)
    );

    wcm_frame_scan u_scan (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_ctrl     (scan_ctrl),
        .i_frame    (new_frame),
        .o_row      (scan_row),
        .o_row_bits (scan_bits)
    );

    // result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (out_free) begin
            r_out_valid <= scan_ctrl.step;
        end
    end

    always_ff @(posedge i_clk) begin
        if (scan_ctrl.step) begin
            r_row_enable   <= ROWS'(1) << scan_row;
            r_column_drive <= scan_bits;
            r_row_number   <= scan_row;
        end
    end

    assign o_valid        = r_out_valid;
    assign o_row_enable   = r_row_enable;
    assign o_column_drive = r_column_drive;
    assign o_row_number   = r_row_number;

    // checks
    `WCM_ASSERT_NOW(a_row_onehot, o_valid, o_row_enable == (ROWS'(1) << o_row_number), "row enable does not match row number")
    `WCM_ASSERT_NOW(a_row_range, o_valid, o_row_number <= LAST_ROW, "row number out of range")
    `WCM_ASSERT_NEXT(a_scan_result, scan_ctrl.step, o_valid, "scan tick gave no result")
    `WCM_ASSERT_NOW(a_stall_held, o_stall, r_in_valid && !r_kind && r_out_valid, "stall without a blocked scan tick")

endmodule

// File: tb/tb_top.sv
// self-checking testbench for the word clock matrix driver
module tb_top;
    import wcm_pkg::*;

    typedef enum logic {
        ITEM_SCAN     = 1'b0,
        ITEM_SET_TIME = 1'b1
    } t_item_kind;

    typedef struct {
        t_item_kind kind;
        logic [4:0] hour;
        logic [5:0] minute;
        logic       sync_flag;
        bit         drain_first;
    } t_clock_item;

    typedef struct packed {
        logic [9:0] row_enable;
        t_row       column_drive;
        t_row_idx   row_number;
    } t_row_scan;

    localparam int          RANDOM_ITEMS  = 1050;
    localparam int unsigned QUIET_LIMIT   = 5000;
    localparam int          SETTLE_CYCLES = 8;
    localparam int          REPORT_MAX    = 10;

    // idle and stall percentages per phase of the run
    localparam int SEND_IDLE_PCT [3]  = '{29, 77, 0};
    localparam int RECV_STALL_PCT [3] = '{77, 29, 0};

    // fixed words of the layout
    localparam t_row     WORD_E           = 12'h800;
    localparam t_row_idx WORD_E_ROW       = 4'd7;
    localparam t_row     WORD_MENO        = 12'h01E;
    localparam t_row_idx WORD_MENO_ROW    = 4'd6;
    localparam t_row     MINUTE_DOT       = 12'h001;
    localparam t_row     WORD_E_L         = 12'hA00;
    localparam t_row_idx WORD_E_L_ROW     = 4'd1;
    localparam t_row     WORD_SONO_LE_ORE = 12'hF6E;
    localparam t_row_idx WORD_SONO_ROW    = 4'd0;
    localparam int       FIRST_MENO_MIN   = 35;

    // minute words by five-minute step, hour words by displayed hour
    localparam t_row_idx MINUTE_WORD_ROW [13] = '{
        4'd0, 4'd8, 4'd9, 4'd7, 4'd8, 4'd8, 4'd9, 4'd8, 4'd8, 4'd7, 4'd9, 4'd8, 4'd0
    };
    localparam t_row MINUTE_WORD_BITS [13] = '{
        12'h000, 12'h07E, 12'hF80, 12'h37E, 12'hF80, 12'hFFE, 12'h03E,
        12'hFFE, 12'hF80, 12'h37E, 12'hF80, 12'h07E, 12'h000
    };
    localparam t_row_idx HOUR_WORD_ROW [12] = '{
        4'd4, 4'd1, 4'd1, 4'd2, 4'd5, 4'd6, 4'd5, 4'd4, 4'd2, 4'd2, 4'd3, 4'd3
    };
    localparam t_row HOUR_WORD_BITS [12] = '{
        12'hFC0, 12'h1C0, 12'h01C, 12'hE00, 12'hFE0, 12'hFC0,
        12'h00E, 12'h03E, 12'h1E0, 12'h01E, 12'hF80, 12'h07E
    };

    logic        i_clk          = 1'b0;
    logic        i_rst_n        = 1'b0;
    logic        i_valid        = 1'b0;
    logic        o_stall;
    logic        i_kind         = 1'b0;
    logic [4:0]  i_hour         = '0;
    logic [5:0]  i_minute       = '0;
    logic        i_sync_flag    = 1'b0;
    logic        o_valid;
    logic        i_stall        = 1'b0;
    logic [9:0]  o_row_enable;
    logic [11:0] o_column_drive;
    logic [3:0]  o_row_number;

    t_clock_item clock_items [$];
    t_row_scan   rows_due [$];
    t_row        lit_rows [ROWS];
    t_row_idx    scan_pos;

    int unsigned total_items;
    int unsigned sent_count;
    int unsigned set_count;
    int unsigned rows_checked;
    int unsigned drain_points;
    int unsigned mismatches;
    int unsigned quiet_cycles;

    word_clock_matrix_driver dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_valid        (i_valid),
        .o_stall        (o_stall),
        .i_kind         (i_kind),
        .i_hour         (i_hour),
        .i_minute       (i_minute),
        .i_sync_flag    (i_sync_flag),
        .o_valid        (o_valid),
        .i_stall        (i_stall),
        .o_row_enable   (o_row_enable),
        .o_column_drive (o_column_drive),
        .o_row_number   (o_row_number)
    );

    // clock
    initial begin
        forever #10 i_clk = ~i_clk;
    end

    // rebuild the frame for a new time
    function automatic void apply_time_setting(logic [4:0] hour, logic [5:0] minute,
                                               logic sync_flag);
        int hr;
        int step;
        int dots;
        int shown;
        hr = hour;
        for (int r = 0; r < ROWS; r++) lit_rows[r] = '0;
        if (minute >= 5) begin
            if (minute < FIRST_MENO_MIN) begin
                lit_rows[WORD_E_ROW] = WORD_E;
            end else begin
                hr = hr + 1;
                lit_rows[WORD_MENO_ROW] = WORD_MENO;
            end
        end
        step = minute / 5;
        if (step > 12) step = 12;
        lit_rows[MINUTE_WORD_ROW[step]] |= MINUTE_WORD_BITS[step];
        // minute dots only while unsynchronized
        if (!sync_flag) begin
            dots = minute % 5;
            for (int i = 0; i < dots; i++) lit_rows[i] |= MINUTE_DOT;
        end
        shown = hr % 12;
        if (shown == 1) lit_rows[WORD_E_L_ROW] |= WORD_E_L;
        else lit_rows[WORD_SONO_ROW] |= WORD_SONO_LE_ORE;
        lit_rows[HOUR_WORD_ROW[shown]] |= HOUR_WORD_BITS[shown];
    endfunction

    // row driven by the next scan tick, then step the row counter
    function automatic t_row_scan take_scan();
        t_row_idx  row;
        t_row_scan r;
        row = scan_pos;
        if (row >= ROWS) row = '0;
        r.row_enable   = 10'(1) << row;
        r.column_drive = lit_rows[row];
        r.row_number   = row;
        scan_pos = (row == LAST_ROW) ? t_row_idx'(0) : row + 1'b1;
        return r;
    endfunction

    function automatic int run_phase();
        if (sent_count * 3 < total_items) return 0;
        if (sent_count * 3 < total_items * 2) return 1;
        return 2;
    endfunction

    function automatic void add_set(int hour, int minute, int sync_flag);
        t_clock_item it;
        it.kind        = ITEM_SET_TIME;
        it.hour        = 5'(hour);
        it.minute      = 6'(minute);
        it.sync_flag   = 1'(sync_flag);
        it.drain_first = ($urandom_range(0, 99) == 0);
        clock_items.push_back(it);
    endfunction

    // scan ticks carry random junk in the ignored fields
    function automatic void add_scans(int count);
        t_clock_item it;
        for (int i = 0; i < count; i++) begin
            it.kind        = ITEM_SCAN;
            it.hour        = 5'($urandom);
            it.minute      = 6'($urandom);
            it.sync_flag   = 1'($urandom);
            it.drain_first = 1'b0;
            clock_items.push_back(it);
        end
    endfunction

    task automatic flag_mismatch(string what, int unsigned want, int unsigned got);
        mismatches++;
        if (mismatches <= REPORT_MAX) begin
            $display("mismatch on %s: expected %0h, got %0h", what, want, got);
        end
    endtask

    // driver: presents pending transactions and predicts each one accepted
    always @(posedge i_clk) begin
        t_clock_item item;
        bit          send_now;
        if (!i_rst_n) begin
            i_valid <= 1'b0;
        end else begin
            if (i_valid && !o_stall) begin
                item = clock_items.pop_front();
                if (item.kind == ITEM_SET_TIME) begin
                    apply_time_setting(item.hour, item.minute, item.sync_flag);
                    set_count++;
                end else begin
                    rows_due.push_back(take_scan());
                end
                sent_count++;
            end
            // a stalled transaction holds, otherwise pick the next one
            if (!i_valid || !o_stall) begin
                send_now = (clock_items.size() != 0);
                if (send_now && clock_items[0].drain_first && rows_due.size() != 0) begin
                    send_now = 1'b0;
                end
                if (send_now && $urandom_range(0, 99) < SEND_IDLE_PCT[run_phase()]) begin
                    send_now = 1'b0;
                end
                i_valid <= send_now;
                if (send_now) begin
                    item = clock_items[0];
                    i_kind      <= item.kind;
                    i_hour      <= item.hour;
                    i_minute    <= item.minute;
                    i_sync_flag <= item.sync_flag;
                end else begin
                    i_kind      <= 1'($urandom);
                    i_hour      <= 5'($urandom);
                    i_minute    <= 6'($urandom);
                    i_sync_flag <= 1'($urandom);
                end
            end
        end
    end

    // monitor: checks each accepted row against the oldest prediction
    always @(posedge i_clk) begin
        t_row_scan want;
        bit        moved;
        if (!i_rst_n) begin
            i_stall <= 1'b0;
        end else begin
            moved = (i_valid && !o_stall) || (o_valid && !i_stall);
            if (o_valid && !i_stall) begin
                if (rows_due.size() == 0) begin
                    flag_mismatch("unexpected row", 0, o_row_number);
                end else begin
                    want = rows_due.pop_front();
                    if (o_row_enable !== want.row_enable) begin
                        flag_mismatch("row_enable", want.row_enable, o_row_enable);
                    end
                    if (o_column_drive !== want.column_drive) begin
                        flag_mismatch("column_drive", want.column_drive, o_column_drive);
                    end
                    if (o_row_number !== want.row_number) begin
                        flag_mismatch("row_number", want.row_number, o_row_number);
                    end
                end
                rows_checked++;
            end
            quiet_cycles <= moved ? 0 : quiet_cycles + 1;
            i_stall <= ($urandom_range(0, 99) < RECV_STALL_PCT[run_phase()]);
        end
    end

    // stimulus, reset and end of run
    initial begin
        int kind_pick;
        int hr;
        int mn;
        for (int r = 0; r < ROWS; r++) lit_rows[r] = '0;
        scan_pos     = '0;
        sent_count   = 0;
        set_count    = 0;
        rows_checked = 0;
        mismatches   = 0;
        quiet_cycles = 0;

        // dark frame, hour one with dots below five minutes, hour 31 at minute 63
        add_scans(3);
        add_set(1, 4, 0);
        add_scans(10);
        add_set(31, 63, 0);
        add_scans(10);

        // mostly a time setting followed by 8 to 14 scan ticks
        while (clock_items.size() < RANDOM_ITEMS) begin
            kind_pick = $urandom_range(0, 9);
            if ($urandom_range(0, 3) == 0) begin
                hr = $urandom_range(0, 7);
                hr = (hr == 0) ? 0 : (hr == 1) ? 1 : (hr == 2) ? 11 : (hr == 3) ? 12 :
                     (hr == 4) ? 13 : (hr == 5) ? 23 : (hr == 6) ? 24 : 31;
            end else begin
                hr = $urandom_range(0, 31);
            end
            if ($urandom_range(0, 3) == 0) begin
                mn = $urandom_range(0, 7);
                mn = (mn == 0) ? 0 : (mn == 1) ? 4 : (mn == 2) ? 5 : (mn == 3) ? 34 :
                     (mn == 4) ? 35 : (mn == 5) ? 59 : (mn == 6) ? 60 : 63;
            end else begin
                mn = $urandom_range(0, 63);
            end
            if (kind_pick < 7) begin
                add_set(hr, mn, $urandom_range(0, 1));
                add_scans($urandom_range(8, 14));
            end else if (kind_pick < 9) begin
                add_set(hr, mn, $urandom_range(0, 1));
            end else begin
                add_scans($urandom_range(1, 5));
            end
        end
        total_items = clock_items.size();

        // always drain at the phase boundaries
        clock_items[total_items / 3].drain_first     = 1'b1;
        clock_items[total_items * 2 / 3].drain_first = 1'b1;
        drain_points = 0;
        foreach (clock_items[i]) if (clock_items[i].drain_first) drain_points++;

        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;

        while (!(clock_items.size() == 0 && rows_due.size() == 0) &&
               quiet_cycles < QUIET_LIMIT) begin
            @(posedge i_clk);
        end

        if (quiet_cycles >= QUIET_LIMIT) begin
            $display("timeout: no transaction for %0d cycles, %0d rows outstanding",
                     QUIET_LIMIT, rows_due.size());
            $display("FAIL word_clock_matrix_driver");
        end else begin
            repeat (SETTLE_CYCLES) @(posedge i_clk);
            $display("run covered %0d transactions: %0d time settings, %0d row scans checked",
                     total_items, set_count, rows_checked);
            $display("three idle/stall phases with %0d drain pauses, %0d mismatches",
                     drain_points, mismatches);
            if (mismatches == 0 && rows_due.size() == 0) begin
                $display("PASS word_clock_matrix_driver");
            end else begin
                $display("FAIL word_clock_matrix_driver");
            end
        end
        $finish;
    end

endmodule
